>>> hdl/fru_pkg.sv
// ---------------------------------------------------------------------------
// fru_pkg
// Shared constants for the unpolarized Fresnel reflectance pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package fru_pkg;

  localparam int VEC_W   = 16;  // Q1.14 vector component
  localparam int IDX_W   = 16;  // Q2.14 refractive index
  localparam int COS_W   = 16;  // Q1.15 cosine, 0..32768
  localparam int OUT_W   = 16;  // Q1.15 reflectance

  localparam logic [COS_W-1:0] COS_ONE   = 16'd32768;
  localparam logic [30:0]      Q30_ONE   = 31'h4000_0000;
  localparam logic [16:0]      Q16_ONE   = 17'h1_0000;
  localparam logic [33:0]      MEAN_RND  = 34'h2_0000;   // half LSB of the >>18
  localparam logic [33:0]      COS_RND   = 34'd4096;     // half LSB of the >>13

endpackage

`default_nettype wire

>>> hdl/fru_div_pipe.sv
// ---------------------------------------------------------------------------
// fru_div_pipe
// Restoring unsigned divider, one quotient bit per register stage.
// Requires num >> QW < den for a meaningful quotient.
// ---------------------------------------------------------------------------
`default_nettype none

module fru_div_pipe #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic          v  [QW+1];
  logic [DW-1:0] r  [QW+1];
  logic [DW-1:0] d  [QW+1];
  logic [QW-1:0] nl [QW+1];
  logic [QW-1:0] q  [QW+1];
  logic [SW-1:0] sd [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= DW'(num[NW-1:QW]);
      d[0]  <= den;
      nl[0] <= num[QW-1:0];
      q[0]  <= '0;
      sd[0] <= side_in;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   t;
    logic          ge;
    logic [DW:0]   diff;

    assign t    = {r[s], nl[s][QW-1]};
    assign ge   = t >= {1'b0, d[s]};
    assign diff = t - {1'b0, d[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[s+1]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        d[s+1]  <= d[s];
        nl[s+1] <= {nl[s][QW-2:0], 1'b0};
        q[s+1]  <= {q[s][QW-2:0], ge};
        sd[s+1] <= sd[s];
      end
    end
  end

  assign out_valid = v[QW];
  assign quo       = q[QW];
  assign side_out  = sd[QW];

endmodule

`default_nettype wire

>>> hdl/fru_sqrt_pipe.sv
// ---------------------------------------------------------------------------
// fru_sqrt_pipe
// Floor square root, one root bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module fru_sqrt_pipe #(
  parameter int RW = 16,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] value,
  input  logic [SW-1:0]   side_in,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  localparam int REM_W = RW + 2;

  logic             v  [RW+1];
  logic [REM_W-1:0] r  [RW+1];
  logic [RW-1:0]    rt [RW+1];
  logic [2*RW-1:0]  vl [RW+1];
  logic [SW-1:0]    sd [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= '0;
      rt[0] <= '0;
      vl[0] <= value;
      sd[0] <= side_in;
    end
  end

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [REM_W+1:0] t;
    logic [REM_W+1:0] trial;
    logic             ge;
    logic [REM_W+1:0] diff;

    assign t     = {r[s], vl[s][2*RW-1:2*RW-2]};
    assign trial = (REM_W+2)'({rt[s], 2'b01});
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[s+1]  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        rt[s+1] <= {rt[s][RW-2:0], ge};
        vl[s+1] <= {vl[s][2*RW-3:0], 2'b00};
        sd[s+1] <= sd[s];
      end
    end
  end

  assign out_valid = v[RW];
  assign root      = rt[RW];
  assign side_out  = sd[RW];

endmodule

`default_nettype wire

>>> hdl/fresnel_reflectance_unit.sv
// ---------------------------------------------------------------------------
// fresnel_reflectance_unit
// Unpolarized Fresnel reflectance with total internal reflection flag.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle unless a held result stalls the pipe;
// every step is its own register stage.
// Depth is set by the bit-serial stages: 31 for sinT2, 16 for the square
// root, 17 for the two ratio divisions (run side by side).
// Reset (rst, synchronous) clears all valid bits; payload is not reset.
`default_nettype none

module fresnel_reflectance_unit (
  input  logic                      clk,
  input  logic                      rst,
  // input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [15:0]        normal_x,
  input  logic signed [15:0]        normal_y,
  input  logic signed [15:0]        normal_z,
  input  logic signed [15:0]        incident_x,
  input  logic signed [15:0]        incident_y,
  input  logic signed [15:0]        incident_z,
  input  logic [fru_pkg::IDX_W-1:0] index_from,
  input  logic [fru_pkg::IDX_W-1:0] index_to,
  // output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [fru_pkg::OUT_W-1:0] reflectance,
  output logic                      total_internal
);

  import fru_pkg::*;

  // Global advance: the pipe moves unless a held result blocks the last stage.
  logic en;
  logic v8;
  assign en       = !out_valid || !out_stall || !v8;
  assign in_stall = !en;

  // ---- stage 1: dot product terms and index squares --------------------
  logic               v1;
  logic signed [31:0] p0, p1, p2;
  logic [15:0]        n1_1, n2_1;
  logic [31:0]        n1sq_1, n2sq_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0     <= normal_x * incident_x;
      p1     <= normal_y * incident_y;
      p2     <= normal_z * incident_z;
      n1_1   <= index_from;
      n2_1   <= index_to;
      n1sq_1 <= index_from * index_from;
      n2sq_1 <= index_to * index_to;
    end
  end

  // ---- stage 2: cosI = -dot, rounded into Q1.15 and clamped ------------
  logic signed [33:0] dot, negdot, ndr;
  logic [COS_W-1:0]   cosi_c;

  assign dot    = 34'(p0) + 34'(p1) + 34'(p2);
  assign negdot = -dot;
  assign ndr    = negdot + $signed(COS_RND);

  always_comb begin
    if (negdot <= 0) begin
      cosi_c = '0;
    end else if (ndr[33:13] > 21'(COS_ONE)) begin
      cosi_c = COS_ONE;
    end else begin
      cosi_c = ndr[28:13];
    end
  end

  logic             v2;
  logic [COS_W-1:0] cosi_2;
  logic [15:0]      n1_2, n2_2;
  logic [31:0]      n1sq_2, n2sq_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cosi_2 <= cosi_c;
      n1_2   <= n1_1;
      n2_2   <= n2_1;
      n1sq_2 <= n1sq_1;
      n2sq_2 <= n2sq_1;
    end
  end

  // ---- stage 3: 1 - cosI^2 in Q.30 --------------------------------------
  logic [31:0] cos_sq;
  assign cos_sq = cosi_2 * cosi_2;

  logic             v3;
  logic [30:0]      om_3;
  logic [COS_W-1:0] cosi_3;
  logic [15:0]      n1_3, n2_3;
  logic [31:0]      n1sq_3, n2sq_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      om_3   <= Q30_ONE - cos_sq[30:0];
      cosi_3 <= cosi_2;
      n1_3   <= n1_2;
      n2_3   <= n2_2;
      n1sq_3 <= n1sq_2;
      n2sq_3 <= n2sq_2;
    end
  end

  // ---- stage 4: lhs = n1^2 * (1 - cosI^2) --------------------------------
  logic [62:0] lhs_prod;
  assign lhs_prod = 63'(n1sq_3) * 63'(om_3);

  logic             v4;
  logic [61:0]      lhs_4;
  logic [31:0]      n2sq_4;
  logic [COS_W-1:0] cosi_4;
  logic [15:0]      n1_4, n2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lhs_4  <= lhs_prod[61:0];
      n2sq_4 <= n2sq_3;
      cosi_4 <= cosi_3;
      n1_4   <= n1_3;
      n2_4   <= n2_3;
    end
  end

  // TIR test is exact; the quotient only matters when it is clear.
  logic tir_4, zero_4;
  assign tir_4  = lhs_4 > {n2sq_4, 30'd0};
  assign zero_4 = n2sq_4 == '0;

  // ---- sinT2 = lhs / n2^2 -----------------------------------------------
  logic             dv1_valid;
  logic [30:0]      sint2_q;
  logic [49:0]      dv1_side;

  fru_div_pipe #(.NW(62), .DW(32), .QW(31), .SW(50)) u_sint2_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .num       (lhs_4),
    .den       (n2sq_4),
    .side_in   ({tir_4, zero_4, cosi_4, n1_4, n2_4}),
    .out_valid (dv1_valid),
    .quo       (sint2_q),
    .side_out  (dv1_side)
  );

  logic             tir_5, zero_5;
  logic [COS_W-1:0] cosi_5;
  logic [15:0]      n1_5, n2_5;
  logic [30:0]      sint2, cost_sq;

  assign {tir_5, zero_5, cosi_5, n1_5, n2_5} = dv1_side;

  always_comb begin
    if (zero_5) begin
      sint2 = '0;
    end else if (sint2_q > Q30_ONE) begin
      sint2 = Q30_ONE;
    end else begin
      sint2 = sint2_q;
    end
  end
  assign cost_sq = Q30_ONE - sint2;

  // ---- cosT = floor(sqrt(1 - sinT2)) ------------------------------------
  logic             sq_valid;
  logic [15:0]      cost;
  logic [48:0]      sq_side;

  fru_sqrt_pipe #(.RW(16), .SW(49)) u_cost_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv1_valid),
    .value     ({1'b0, cost_sq}),
    .side_in   ({tir_5, cosi_5, n1_5, n2_5}),
    .out_valid (sq_valid),
    .root      (cost),
    .side_out  (sq_side)
  );

  logic             tir_6i;
  logic [COS_W-1:0] cosi_6i;
  logic [15:0]      n1_6i, n2_6i;
  assign {tir_6i, cosi_6i, n1_6i, n2_6i} = sq_side;

  // ---- stage 6: n * cos products ----------------------------------------
  logic [31:0] xs_p, ys_p, xp_p, yp_p;
  assign xs_p = n1_6i * cosi_6i;
  assign ys_p = n2_6i * cost;
  assign xp_p = n1_6i * cost;
  assign yp_p = n2_6i * cosi_6i;

  logic        v6, tir_6;
  logic [30:0] xs, ys, xp, yp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs    <= xs_p[30:0];
      ys    <= ys_p[30:0];
      xp    <= xp_p[30:0];
      yp    <= yp_p[30:0];
      tir_6 <= tir_6i;
    end
  end

  // Ratio operands: |x - y| * 2^16 + (x + y) / 2 over (x + y).
  logic [31:0] den_s, den_p;
  logic [30:0] mag_s, mag_p;
  logic [47:0] num_s, num_p;

  assign den_s = 32'(xs) + 32'(ys);
  assign den_p = 32'(xp) + 32'(yp);
  assign mag_s = (xs > ys) ? xs - ys : ys - xs;
  assign mag_p = (xp > yp) ? xp - yp : yp - xp;
  assign num_s = 48'({mag_s, 16'd0}) + 48'(den_s[31:1]);
  assign num_p = 48'({mag_p, 16'd0}) + 48'(den_p[31:1]);

  // ---- rs and rp ratios in Q.16 -----------------------------------------
  logic        drs_valid, drp_valid;
  logic [16:0] rs_q, rp_q;
  logic [1:0]  drs_side;
  logic        drp_side;

  fru_div_pipe #(.NW(48), .DW(32), .QW(17), .SW(2)) u_rs_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .num       (num_s),
    .den       (den_s),
    .side_in   ({tir_6, den_s == '0}),
    .out_valid (drs_valid),
    .quo       (rs_q),
    .side_out  (drs_side)
  );

  fru_div_pipe #(.NW(48), .DW(32), .QW(17), .SW(1)) u_rp_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v6),
    .num       (num_p),
    .den       (den_p),
    .side_in   (den_p == '0),
    .out_valid (drp_valid),
    .quo       (rp_q),
    .side_out  (drp_side)
  );

  // Zero denominator counts as a ratio of one.
  logic [16:0] rs, rp;
  assign rs = (drs_side[0] || rs_q > Q16_ONE) ? Q16_ONE : rs_q;
  assign rp = (drp_side    || rp_q > Q16_ONE) ? Q16_ONE : rp_q;

  // ---- stage 8: squares in Q.32 -----------------------------------------
  logic [33:0] rs_sq, rp_sq;
  assign rs_sq = 34'(rs) * 34'(rs);
  assign rp_sq = 34'(rp) * 34'(rp);

  logic        tir_8;
  logic [32:0] rs2, rp2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= drs_valid && drp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs2   <= rs_sq[32:0];
      rp2   <= rp_sq[32:0];
      tir_8 <= drs_side[1];
    end
  end

  // ---- mean, rounding, saturation; output register ----------------------
  logic [33:0]      mean_sum;
  logic [OUT_W-1:0] refl_c;

  assign mean_sum = 34'(rs2) + 34'(rp2) + MEAN_RND;

  always_comb begin
    if (tir_8 || mean_sum[33:18] > COS_ONE) begin
      refl_c = COS_ONE;
    end else begin
      refl_c = mean_sum[33:18];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      reflectance    <= refl_c;
      total_internal <= tir_8;
    end
  end

endmodule

`default_nettype wire

>>> hdl/fru_checker.sv
// ---------------------------------------------------------------------------
// fru_checker
// Port-level checks on the Fresnel reflectance unit, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module fru_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [15:0] reflectance,
  input wire        total_internal
);

  // held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reflectance) &&
      $stable(total_internal))
    else $error("output changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reflectance <= 16'd32768)
    else $error("reflectance above one");

  a_tir: assert property (@(posedge clk) disable iff (rst)
    out_valid && total_internal |-> reflectance == 16'd32768)
    else $error("TIR without full reflectance");

  // input side only backs up behind a held result
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind fresnel_reflectance_unit fru_checker u_fru_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .reflectance    (reflectance),
  .total_internal (total_internal)
);

`default_nettype wire

>>> sim/tb_fresnel_reflectance_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_fresnel_reflectance_unit
// Self-checking bench: random and directed geometry/index items, a bit-exact
// reflectance predictor, randomized input valid and output stall.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_fresnel_reflectance_unit;
  import fru_pkg::*;

  typedef struct packed {
    logic signed [15:0] nx, ny, nz, ix, iy, iz;
    logic [15:0] n1, n2;
  } hit_t;

  typedef struct packed {
    logic [15:0] refl;
    logic        tir;
  } refl_t;

  localparam int LATENCY   = 74;
  localparam int CYCLE_MAX = 400000;
  localparam int N_RANDOM  = 1700;
  localparam int HOLD_LEN  = 300;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic signed [15:0] normal_x = 0, normal_y = 0, normal_z = 0;
  logic signed [15:0] incident_x = 0, incident_y = 0, incident_z = 0;
  logic [15:0] index_from = 16'h4000, index_to = 16'h4000;
  logic in_stall, out_valid, total_internal;
  logic [15:0] reflectance;

  hit_t  pending_hits[$];
  refl_t expected_refl[$];
  int    n_errors = 0, n_results = 0, n_tir = 0, cycle_cnt = 0;
  bit    idle_free = 0;   // long stretch with no idling on either side
  bit    hold_go = 0;     // sequence asks for one long receiver hold-off
  bit    hold_done = 0;   // hold-off already started
  int    hold_off = 0;    // receiver hold-off, in cycles
  bit    sender_pause = 0;

  fresnel_reflectance_unit DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // ---- predictor --------------------------------------------------------
  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 30;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // squared Fresnel term in Q.32; zero denominator counts as 1.0
  function automatic logic [63:0] fresnel_sq(logic [63:0] x, logic [63:0] y);
    logic [63:0] den, num, r;
    den = x + y;
    num = (x > y) ? x - y : y - x;
    if (den == 0) return 64'd1 << 32;
    r = ((num << 16) + (den >> 1)) / den;
    if (r > 64'd65536) r = 64'd65536;
    return r * r;
  endfunction

  function automatic refl_t predict_reflectance(hit_t h);
    longint dot;
    logic [63:0] cosi, om, lhs, n2sq, sint2, cost, rs2, rp2, m, n1, n2;
    refl_t r;
    dot = longint'(h.nx) * h.ix + longint'(h.ny) * h.iy + longint'(h.nz) * h.iz;
    n1 = h.n1;
    n2 = h.n2;
    if (-dot <= 0) cosi = 0;
    else begin
      cosi = (64'(-dot) + 64'd4096) >> 13;
      if (cosi > 64'd32768) cosi = 64'd32768;
    end
    om = (64'd1 << 30) - cosi * cosi;
    lhs = n1 * n1 * om;
    n2sq = n2 * n2;
    if (lhs > (n2sq << 30)) begin
      r.refl = 16'd32768;
      r.tir = 1;
      return r;
    end
    sint2 = (n2sq == 0) ? 64'd0 : lhs / n2sq;
    if (sint2 > (64'd1 << 30)) sint2 = 64'd1 << 30;
    cost = isqrt((64'd1 << 30) - sint2);
    rs2 = fresnel_sq(n1 * cosi, n2 * cost);
    rp2 = fresnel_sq(n1 * cost, n2 * cosi);
    m = (rs2 + rp2 + (64'd1 << 17)) >> 18;
    if (m > 64'd32768) m = 64'd32768;
    r.refl = m[15:0];
    r.tir = 0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", n_results, what, got, want);
  endtask

  // ---- stimulus helpers -------------------------------------------------
  function automatic logic signed [15:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);               // any bit pattern
      default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  function automatic logic [15:0] rnd_index();
    case ($urandom_range(0, 7))
      0: return 16'h4000;
      1: return 16'hFFFF;
      2: return 16'($urandom);               // includes zero and tiny
      default: return 16'($urandom_range(16384, 40000));
    endcase
  endfunction

  // roughly unit vectors so cosI covers the whole [0,1] range
  function automatic hit_t rnd_hit();
    hit_t h;
    real a, b, c, d, e, f, l;
    if ($urandom_range(0, 9) == 0) begin
      h = {rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(),
           rnd_index(), rnd_index()};
      return h;
    end
    a = $itor($urandom_range(0, 2000)) - 1000.0;
    b = $itor($urandom_range(0, 2000)) - 1000.0;
    c = $itor($urandom_range(0, 2000)) - 1000.0 + 0.5;
    l = $sqrt(a*a + b*b + c*c);
    d = $itor($urandom_range(0, 2000)) - 1000.0;
    e = $itor($urandom_range(0, 2000)) - 1000.0;
    f = $itor($urandom_range(0, 2000)) - 1000.0 + 0.5;
    h.nx = 16'($rtoi(a / l * 16384.0));
    h.ny = 16'($rtoi(b / l * 16384.0));
    h.nz = 16'($rtoi(c / l * 16384.0));
    l = $sqrt(d*d + e*e + f*f);
    h.ix = 16'($rtoi(d / l * 16384.0));
    h.iy = 16'($rtoi(e / l * 16384.0));
    h.iz = 16'($rtoi(f / l * 16384.0));
    h.n1 = rnd_index();
    h.n2 = rnd_index();
    return h;
  endfunction

  // ---- driver -----------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (!(in_valid && in_stall)) begin
        if (in_valid) expected_refl.push_back(predict_reflectance(
            {normal_x, normal_y, normal_z, incident_x, incident_y, incident_z,
             index_from, index_to}));
        if (pending_hits.size() > 0 && !sender_pause &&
            (idle_free || $urandom_range(0, 99) >= 10)) begin
          hit_t h;
          h = pending_hits.pop_front();
          {normal_x, normal_y, normal_z, incident_x, incident_y, incident_z,
           index_from, index_to} <= h;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // ---- monitor and receiver stall ---------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        refl_t want;
        n_results++;
        if (expected_refl.size() == 0) begin
          report_mismatch("unexpected transfer", reflectance, -1);
        end else begin
          want = expected_refl.pop_front();
          if (reflectance !== want.refl) report_mismatch("reflectance", reflectance, want.refl);
          if (total_internal !== want.tir) report_mismatch("total_internal", total_internal, want.tir);
          if (want.tir) n_tir++;
        end
      end
      if (hold_go && !hold_done) begin
        hold_done <= 1;
        hold_off <= HOLD_LEN - 1;
        out_stall <= 1;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1;
      end else begin
        out_stall <= !idle_free && ($urandom_range(0, 99) < 10);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_fresnel_reflectance_unit NOT OK");
      $finish;
    end
  end

  // ---- sequence ---------------------------------------------------------
  initial begin
    hit_t h;
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed: normal incidence, grazing, back-facing, over-long, TIR,
    // zero indices, extreme fields
    pending_hits.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, -16'sd16384,
                            16'h4000, 16'h6000});
    pending_hits.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0,
                            16'h4000, 16'h6000});
    pending_hits.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384,
                            16'h4000, 16'h6000});
    pending_hits.push_back({16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384,
                            -16'sd16384, 16'h4000, 16'h4000});
    pending_hits.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd15000, 16'sd0, -16'sd6000,
                            16'h6000, 16'h4000});
    pending_hits.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, -16'sd16384,
                            16'h0000, 16'h0000});
    pending_hits.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd8000, 16'sd0, -16'sd14000,
                            16'h4000, 16'h0000});
    pending_hits.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, -16'sd16384,
                            16'h0000, 16'h4000});
    pending_hits.push_back({-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                            -16'sd32768, -16'sd32768, 16'hFFFF, 16'hFFFF});
    pending_hits.push_back({16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                            16'sh7FFF, 16'hFFFF, 16'h4000});
    pending_hits.push_back({-16'sd32768, 16'sh7FFF, 16'sd0, 16'sh7FFF, -16'sd32768,
                            16'sd0, 16'h4000, 16'hFFFF});
    pending_hits.push_back({16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, -16'sd1,
                            16'hFFFF, 16'h4000});

    // sender pause: wait for every expected result to drain
    wait (pending_hits.size() == 0);
    sender_pause = 1;
    wait (!in_valid && expected_refl.size() == 0);
    sender_pause = 0;

    // random with long receiver hold-off so the pipeline fills
    repeat (300) pending_hits.push_back(rnd_hit());
    @(posedge clk);
    hold_go = 1;
    repeat (N_RANDOM - 300) pending_hits.push_back(rnd_hit());

    // stretch without idling once the hold-off is over
    wait (pending_hits.size() < 900);
    idle_free = 1;
    wait (pending_hits.size() < 500);
    idle_free = 0;

    wait (pending_hits.size() == 0 && !in_valid);
    wait (expected_refl.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);

    $display("checked %0d results, %0d of them total internal reflection,", n_results, n_tir);
    $display("covering clamped cosines, zero indices and saturated stalls");
    if (n_errors == 0 && expected_refl.size() == 0)
      $display("tb_fresnel_reflectance_unit OK");
    else
      $display("tb_fresnel_reflectance_unit NOT OK");
    $finish;
  end
endmodule

`default_nettype wire

>>> sim.f
hdl/fru_pkg.sv
hdl/fru_div_pipe.sv
hdl/fru_sqrt_pipe.sv
hdl/fresnel_reflectance_unit.sv
hdl/fru_checker.sv
sim/tb_fresnel_reflectance_unit.sv
